// ----- sv/prfp_pkg.sv -----
// ----------------------------------------------------------------------------
// prfp_pkg
// Shared types, constants and series tables for the body pose ramp and foot
// position solver.
// ----------------------------------------------------------------------------
package prfp_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int COORD_BITS_DEF = 24;

	localparam int CFG_W     = 20;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W    = 12;
	localparam int TGT_W     = 16;

	localparam int DEG_FULL     = 92160;
	localparam int DEG_QUAD     = 23040;
	localparam int RAD_PER_UNIT = 73204;
	localparam int RAMP_DEAD    = 256;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	localparam logic [CFG_W-1:0] HIP_BASE_RST   = 20'd51200;
	localparam logic [CFG_W-1:0] HIP_TRACK_RST  = 20'd25600;
	localparam logic [CFG_W-1:0] FOOT_TRACK_RST = 20'd25600;
	localparam logic [CFG_W-1:0] STAND_RST      = 20'd38400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIP_BASE   = 3'd0,
		REG_HIP_TRACK  = 3'd1,
		REG_FOOT_TRACK = 3'd2,
		REG_STAND      = 3'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_RED, ST_QUAD, ST_X2M, ST_X2, ST_MT, ST_MR, ST_CR,
		ST_FIN, ST_FIN2, ST_PM, ST_PR, ST_OUT
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Horner divisors of the sine and cosine series.
	function automatic logic [7:0] series_div(input logic cos_pass, input logic [2:0] idx);
		case ({cos_pass, idx})
			4'b0000: series_div = 8'd110;
			4'b0001: series_div = 8'd72;
			4'b0010: series_div = 8'd42;
			4'b0011: series_div = 8'd20;
			4'b0100: series_div = 8'd6;
			4'b1000: series_div = 8'd132;
			4'b1001: series_div = 8'd90;
			4'b1010: series_div = 8'd56;
			4'b1011: series_div = 8'd30;
			4'b1100: series_div = 8'd12;
			default: series_div = 8'd1;
		endcase
	endfunction

	// floor(2^34 / divisor); the quotient is then off by at most one.
	function automatic logic [31:0] series_recip(input logic cos_pass, input logic [2:0] idx);
		case ({cos_pass, idx})
			4'b0000: series_recip = 32'd156180628;
			4'b0001: series_recip = 32'd238609294;
			4'b0010: series_recip = 32'd409044504;
			4'b0011: series_recip = 32'd858993459;
			4'b0100: series_recip = 32'd2863311530;
			4'b1000: series_recip = 32'd130150524;
			4'b1001: series_recip = 32'd190887435;
			4'b1010: series_recip = 32'd306783378;
			4'b1011: series_recip = 32'd572662306;
			4'b1100: series_recip = 32'd1431655765;
			default: series_recip = 32'hFFFF_FFFF;
		endcase
	endfunction

endpackage

// ----- sv/prfp_front.sv -----
// ----------------------------------------------------------------------------
// prfp_front
// Accepts input items, ramps pitch, roll and shift toward their targets and
// pushes the new running values into the queue.
// ----------------------------------------------------------------------------
module prfp_front #(
	parameter int ANGLE_BITS = prfp_pkg::ANGLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [prfp_pkg::TGT_W-1:0]  target_pitch,
	input  logic signed [prfp_pkg::TGT_W-1:0]  target_roll,
	input  logic signed [prfp_pkg::TGT_W-1:0]  target_shift,
	input  logic        [prfp_pkg::STEP_W-1:0] step_size,
	input  prfp_pkg::q_stat_t              q_stat,
	output logic                           push,
	output logic        [3*ANGLE_BITS-1:0] push_data
);

	localparam int RW = ((ANGLE_BITS > prfp_pkg::TGT_W) ? ANGLE_BITS : prfp_pkg::TGT_W) + 3;
	localparam logic signed [RW-1:0] AMAX = {{(RW-ANGLE_BITS+1){1'b0}}, {(ANGLE_BITS-1){1'b1}}};
	localparam logic signed [RW-1:0] AMIN = ~AMAX;
	localparam logic signed [RW-1:0] DEAD = RW'(prfp_pkg::RAMP_DEAD);

	logic signed [ANGLE_BITS-1:0] pitch_now_q, roll_now_q, shift_now_q;
	logic signed [ANGLE_BITS-1:0] pitch_nxt, roll_nxt, shift_nxt;

	function automatic logic signed [ANGLE_BITS-1:0] ramp(
		input logic signed [ANGLE_BITS-1:0] cur,
		input logic signed [prfp_pkg::TGT_W-1:0] tgt,
		input logic [prfp_pkg::STEP_W-1:0] step
	);
		logic signed [RW-1:0] c, t, s, n;
		c = RW'(cur);
		t = RW'(tgt);
		s = RW'(signed'({1'b0, step}));
		if (t - c > DEAD)
			n = c + s;
		else if (c - t > DEAD)
			n = c - s;
		else
			n = c;
		if (n > AMAX)
			n = AMAX;
		else if (n < AMIN)
			n = AMIN;
		ramp = n[ANGLE_BITS-1:0];
	endfunction

	assign in_stall = q_stat.full;
	assign push     = in_valid & ~q_stat.full;

	always_comb begin
		pitch_nxt = ramp(pitch_now_q, target_pitch, step_size);
		roll_nxt  = ramp(roll_now_q, target_roll, step_size);
		shift_nxt = ramp(shift_now_q, target_shift, step_size);
	end

	assign push_data = {shift_nxt, roll_nxt, pitch_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_now_q <= '0;
			roll_now_q  <= '0;
			shift_now_q <= '0;
		end else if (push) begin
			pitch_now_q <= pitch_nxt;
			roll_now_q  <= roll_nxt;
			shift_now_q <= shift_nxt;
		end
	end

endmodule

// ----- sv/prfp_queue.sv -----
// ----------------------------------------------------------------------------
// prfp_queue
// Two-entry queue of ramped pose values between the front and the back.
// ----------------------------------------------------------------------------
module prfp_queue #(
	parameter int DW = 3 * prfp_pkg::ANGLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DW-1:0]     push_data,
	input  logic              pop,
	output logic [DW-1:0]     head,
	output prfp_pkg::q_stat_t stat
);

	logic [DW-1:0] mem_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ----- sv/prfp_back.sv -----
// ----------------------------------------------------------------------------
// prfp_back
// Sequencer around one shared multiplier: angle reduction, series sine and
// cosine, the rotation products and the four leg results.
// ----------------------------------------------------------------------------
module prfp_back #(
	parameter int ANGLE_BITS = prfp_pkg::ANGLE_BITS_DEF,
	parameter int COORD_BITS = prfp_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [3*ANGLE_BITS-1:0]       head,
	input  prfp_pkg::q_stat_t             q_stat,
	output logic                          pop,
	input  logic [prfp_pkg::CFG_W-1:0]    hip_base_length,
	input  logic [prfp_pkg::CFG_W-1:0]    hip_track_width,
	input  logic [prfp_pkg::CFG_W-1:0]    foot_track_width,
	input  logic [prfp_pkg::CFG_W-1:0]    stand_height,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    leg_index,
	output logic signed [COORD_BITS-1:0]  foot_x,
	output logic signed [COORD_BITS-1:0]  foot_y,
	output logic signed [COORD_BITS-1:0]  foot_z,
	output logic                          last_leg
);

	localparam int RDW   = ((ANGLE_BITS > 17) ? ANGLE_BITS : 17) + 1;
	localparam int RED_K = RDW - 16;
	localparam int KW    = (RED_K > 0) ? $clog2(RED_K + 1) : 1;
	localparam int NOFF  = ((1 << (ANGLE_BITS - 1)) + prfp_pkg::DEG_FULL - 1) / prfp_pkg::DEG_FULL;
	localparam logic [RDW-1:0] OFFSET = RDW'(NOFF * prfp_pkg::DEG_FULL);
	localparam int SUM_W = ((ANGLE_BITS > 22) ? ANGLE_BITS : 22) + 3;
	localparam int EW    = ((SUM_W > COORD_BITS) ? SUM_W : COORD_BITS) + 1;
	localparam logic signed [EW-1:0] CMAX = {{(EW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [EW-1:0] CMIN = ~CMAX;

	prfp_pkg::back_state_t state_q, state_d;

	logic signed [ANGLE_BITS-1:0] pitch_q, roll_q, shift_q;
	logic                         sel_q, cosp_q;
	logic [RDW-1:0]               v_q;
	logic [KW-1:0]                k_q;
	logic [1:0]                   quad_q;
	logic [31:0]                  x_q, x2_q, m_q;
	logic [30:0]                  t_q, sraw_q;
	logic [2:0]                   i_q, op_q;
	logic [1:0]                   leg_q;
	logic signed [31:0]           sp_q, cp_q, sr_q, cr_q;
	logic signed [31:0]           res_q [7];
	logic signed [65:0]           prod_q;
	logic signed [32:0]           mul_a, mul_b;
	logic                         ov_q, load_out;
	logic signed [COORD_BITS-1:0] fx_q, fy_q, fz_q;
	logic [1:0]                   lidx_q;

	// Combinational helpers
	logic [RDW:0]          red_cmp;
	logic [16:0]           m_red;
	logic [1:0]            quad;
	logic [14:0]           r_quad;
	logic [29:0]           q0;
	logic [39:0]           rem;
	logic [30:0]           qq, t_next;
	logic [7:0]            dv;
	logic signed [32:0]    cv;
	logic [30:0]           qc;
	logic signed [31:0]    qs32, qc32, s_map, c_map;
	logic signed [31:0]    rnd;
	logic signed [SUM_W-1:0] tx, ty, tz;

	function automatic logic signed [31:0] round30(input logic signed [65:0] p);
		logic        neg;
		logic [65:0] mag, u;
		neg = p[65];
		mag = neg ? 66'(-p) : 66'(p);
		u   = (mag + (66'd1 << 29)) >> 30;
		round30 = neg ? -signed'(u[31:0]) : signed'(u[31:0]);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] coord(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W:0] w, h;
		logic signed [EW-1:0]  e;
		w = (SUM_W+1)'(v);
		if (w < 0)
			h = -((-w + 1) >>> 1);
		else
			h = (w + 1) >>> 1;
		e = EW'(h);
		if (e > CMAX)
			e = CMAX;
		else if (e < CMIN)
			e = CMIN;
		coord = e[COORD_BITS-1:0];
	endfunction

	always_comb begin
		red_cmp = (RDW+1)'(prfp_pkg::DEG_FULL) << k_q;
		m_red   = v_q[16:0];
		if (m_red >= 17'(3 * prfp_pkg::DEG_QUAD))
			quad = 2'd3;
		else if (m_red >= 17'(2 * prfp_pkg::DEG_QUAD))
			quad = 2'd2;
		else if (m_red >= 17'(prfp_pkg::DEG_QUAD))
			quad = 2'd1;
		else
			quad = 2'd0;
		r_quad = 15'(m_red - 17'(quad) * 17'(prfp_pkg::DEG_QUAD));

		dv     = prfp_pkg::series_div(cosp_q, i_q);
		q0     = prod_q[63:34];
		rem    = 40'(m_q) - 40'(q0) * 40'(dv);
		qq     = 31'(q0) + 31'(rem >= 40'(dv));
		t_next = prfp_pkg::Q30_ONE - qq;

		cv = signed'({2'b0, prfp_pkg::Q30_ONE}) - signed'({1'b0, prod_q[62:31]});
		qc = (cv < 0) ? 31'd0 : cv[30:0];
		qs32 = signed'({1'b0, sraw_q});
		qc32 = signed'({1'b0, qc});
		case (quad_q)
			2'd0:    begin s_map = qs32;  c_map = qc32;  end
			2'd1:    begin s_map = qc32;  c_map = -qs32; end
			2'd2:    begin s_map = -qs32; c_map = -qc32; end
			default: begin s_map = -qc32; c_map = qs32;  end
		endcase

		rnd = round30(prod_q);
	end

	// Shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			prfp_pkg::ST_X2M: begin
				mul_a = signed'({1'b0, x_q});
				mul_b = signed'({1'b0, x_q});
			end
			prfp_pkg::ST_MT: begin
				mul_a = signed'({1'b0, x2_q});
				mul_b = signed'({2'b0, t_q});
			end
			prfp_pkg::ST_MR: begin
				mul_a = signed'({1'b0, prod_q[61:30]});
				mul_b = signed'({1'b0, prfp_pkg::series_recip(cosp_q, i_q)});
			end
			prfp_pkg::ST_FIN: begin
				mul_a = cosp_q ? signed'({1'b0, x2_q}) : signed'({1'b0, x_q});
				mul_b = signed'({2'b0, t_q});
			end
			prfp_pkg::ST_PM: begin
				case (op_q)
					3'd0:    begin mul_a = 33'(sp_q); mul_b = 33'(sr_q); end
					3'd1:    begin mul_a = 33'(cr_q); mul_b = 33'(sp_q); end
					3'd2:    begin mul_a = signed'(33'(hip_base_length)); mul_b = 33'(cp_q); end
					3'd3:    begin mul_a = signed'(33'(hip_track_width)); mul_b = 33'(cr_q); end
					3'd4:    begin mul_a = signed'(33'(hip_track_width)); mul_b = 33'(sr_q); end
					3'd5:    begin mul_a = signed'(33'(hip_base_length)); mul_b = 33'(res_q[0]); end
					default: begin mul_a = signed'(33'(hip_base_length)); mul_b = 33'(res_q[1]); end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Leg terms at twice scale
	always_comb begin
		logic signed [SUM_W-1:0] l, w, h2, s2, lc, bc, bs, lss, lcs;
		l   = signed'(SUM_W'(hip_base_length));
		w   = signed'(SUM_W'(foot_track_width));
		h2  = signed'(SUM_W'(stand_height)) <<< 1;
		s2  = SUM_W'(shift_q) <<< 1;
		lc  = SUM_W'(res_q[2]);
		bc  = SUM_W'(res_q[3]);
		bs  = SUM_W'(res_q[4]);
		lss = SUM_W'(res_q[5]);
		lcs = SUM_W'(res_q[6]);
		tx = leg_q[1] ? (lc - l - s2) : (l - s2 - lc);
		ty = ((leg_q == 2'd0 || leg_q == 2'd3) ? (w - bc) : (bc - w))
			+ (leg_q[1] ? lss : -lss);
		tz = -h2 + ((leg_q == 2'd0 || leg_q == 2'd3) ? -bs : bs)
			+ (leg_q[1] ? -lcs : lcs);
	end

	assign pop      = (state_q == prfp_pkg::ST_IDLE) && !q_stat.empty;
	assign load_out = (state_q == prfp_pkg::ST_OUT) && (!ov_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prfp_pkg::ST_IDLE: if (!q_stat.empty) state_d = prfp_pkg::ST_LOAD;
			prfp_pkg::ST_LOAD: state_d = prfp_pkg::ST_RED;
			prfp_pkg::ST_RED:  if (k_q == '0) state_d = prfp_pkg::ST_QUAD;
			prfp_pkg::ST_QUAD: state_d = prfp_pkg::ST_X2M;
			prfp_pkg::ST_X2M:  state_d = prfp_pkg::ST_X2;
			prfp_pkg::ST_X2:   state_d = prfp_pkg::ST_MT;
			prfp_pkg::ST_MT:   state_d = prfp_pkg::ST_MR;
			prfp_pkg::ST_MR:   state_d = prfp_pkg::ST_CR;
			prfp_pkg::ST_CR:   state_d = (i_q == 3'd4) ? prfp_pkg::ST_FIN : prfp_pkg::ST_MT;
			prfp_pkg::ST_FIN:  state_d = prfp_pkg::ST_FIN2;
			prfp_pkg::ST_FIN2: begin
				if (!cosp_q)
					state_d = prfp_pkg::ST_MT;
				else if (!sel_q)
					state_d = prfp_pkg::ST_LOAD;
				else
					state_d = prfp_pkg::ST_PM;
			end
			prfp_pkg::ST_PM:   state_d = prfp_pkg::ST_PR;
			prfp_pkg::ST_PR:   state_d = (op_q == 3'd6) ? prfp_pkg::ST_OUT : prfp_pkg::ST_PM;
			prfp_pkg::ST_OUT:  if (load_out && leg_q == 2'd3) state_d = prfp_pkg::ST_IDLE;
			default:           state_d = prfp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= prfp_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q  <= 1'b0;
			cosp_q <= 1'b0;
			i_q    <= '0;
			op_q   <= '0;
			leg_q  <= '0;
			k_q    <= '0;
			ov_q   <= 1'b0;
		end else begin
			case (state_q)
				prfp_pkg::ST_IDLE: sel_q <= 1'b0;
				prfp_pkg::ST_LOAD: k_q <= KW'(RED_K);
				prfp_pkg::ST_RED:  if (k_q != '0) k_q <= k_q - KW'(1);
				prfp_pkg::ST_X2: begin
					i_q    <= '0;
					cosp_q <= 1'b0;
				end
				prfp_pkg::ST_CR:   if (i_q != 3'd4) i_q <= i_q + 3'd1;
				prfp_pkg::ST_FIN2: begin
					i_q <= '0;
					if (!cosp_q) begin
						cosp_q <= 1'b1;
					end else begin
						sel_q <= 1'b1;
						op_q  <= '0;
					end
				end
				prfp_pkg::ST_PR: begin
					op_q  <= op_q + 3'd1;
					leg_q <= '0;
				end
				prfp_pkg::ST_OUT:  if (load_out) leg_q <= leg_q + 2'd1;
				default: ;
			endcase
			if (load_out)
				ov_q <= 1'b1;
			else if (!out_stall)
				ov_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			prfp_pkg::ST_IDLE: begin
				pitch_q <= head[ANGLE_BITS-1:0];
				roll_q  <= head[2*ANGLE_BITS-1:ANGLE_BITS];
				shift_q <= head[3*ANGLE_BITS-1:2*ANGLE_BITS];
			end
			prfp_pkg::ST_LOAD:
				v_q <= RDW'(sel_q ? roll_q : pitch_q) + OFFSET;
			prfp_pkg::ST_RED:
				if ({1'b0, v_q} >= red_cmp) v_q <= v_q - RDW'(red_cmp);
			prfp_pkg::ST_QUAD: begin
				quad_q <= quad;
				x_q    <= 32'(r_quad) * 32'(prfp_pkg::RAD_PER_UNIT);
			end
			prfp_pkg::ST_X2: begin
				x2_q <= prod_q[61:30];
				t_q  <= prfp_pkg::Q30_ONE;
			end
			prfp_pkg::ST_MR:   m_q <= prod_q[61:30];
			prfp_pkg::ST_CR:   t_q <= t_next;
			prfp_pkg::ST_FIN2: begin
				t_q <= prfp_pkg::Q30_ONE;
				if (!cosp_q) begin
					sraw_q <= prod_q[60:30];
				end else if (!sel_q) begin
					sp_q <= s_map;
					cp_q <= c_map;
				end else begin
					sr_q <= s_map;
					cr_q <= c_map;
				end
			end
			prfp_pkg::ST_PR:   res_q[op_q] <= rnd;
			default: ;
		endcase
		if (load_out) begin
			lidx_q <= leg_q;
			fx_q   <= coord(tx);
			fy_q   <= coord(ty);
			fz_q   <= coord(tz);
		end
	end

	assign out_valid = ov_q;
	assign leg_index = lidx_q;
	assign foot_x    = fx_q;
	assign foot_y    = fy_q;
	assign foot_z    = fz_q;
	assign last_leg  = (lidx_q == 2'd3);

endmodule

// ----- sv/pose_ramp_foot_positions_core.sv -----
// ----------------------------------------------------------------------------
// pose_ramp_foot_positions_core
// Body pose ramp and four-leg foot position solver.
// ----------------------------------------------------------------------------
// The four leg results of an item come out one per cycle while out_stall is
// low. One shared 33x33 multiplier is sequenced over the series sine and
// cosine terms and the rotation products, and the solver takes one item at
// a time; a two-entry queue lets the ramp stage accept items while the
// solver works. Reset clears the control, ramp and configuration state, but
// not the datapath registers or the queue storage.
// ----------------------------------------------------------------------------
module pose_ramp_foot_positions_core #(
	parameter int ANGLE_BITS = prfp_pkg::ANGLE_BITS_DEF,
	parameter int COORD_BITS = prfp_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [prfp_pkg::TGT_W-1:0]  target_pitch,
	input  logic signed [prfp_pkg::TGT_W-1:0]  target_roll,
	input  logic signed [prfp_pkg::TGT_W-1:0]  target_shift,
	input  logic        [prfp_pkg::STEP_W-1:0] step_size,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         leg_index,
	output logic signed [COORD_BITS-1:0]       foot_x,
	output logic signed [COORD_BITS-1:0]       foot_y,
	output logic signed [COORD_BITS-1:0]       foot_z,
	output logic                               last_leg,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [prfp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prfp_pkg::CFG_W-1:0]         cfg_data
);

	logic [prfp_pkg::CFG_W-1:0] hip_base_q, hip_track_q, foot_track_q, stand_q;
	logic                       push, pop;
	logic [3*ANGLE_BITS-1:0]    push_data, head;
	prfp_pkg::q_stat_t          q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hip_base_q   <= prfp_pkg::HIP_BASE_RST;
			hip_track_q  <= prfp_pkg::HIP_TRACK_RST;
			foot_track_q <= prfp_pkg::FOOT_TRACK_RST;
			stand_q      <= prfp_pkg::STAND_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				prfp_pkg::REG_HIP_BASE:   hip_base_q   <= cfg_data;
				prfp_pkg::REG_HIP_TRACK:  hip_track_q  <= cfg_data;
				prfp_pkg::REG_FOOT_TRACK: foot_track_q <= cfg_data;
				prfp_pkg::REG_STAND:      stand_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	prfp_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.target_pitch (target_pitch),
		.target_roll  (target_roll),
		.target_shift (target_shift),
		.step_size    (step_size),
		.q_stat       (q_stat),
		.push         (push),
		.push_data    (push_data)
	);

	prfp_queue #(.DW(3 * ANGLE_BITS)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	prfp_back #(.ANGLE_BITS(ANGLE_BITS), .COORD_BITS(COORD_BITS)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.q_stat           (q_stat),
		.pop              (pop),
		.hip_base_length  (hip_base_q),
		.hip_track_width  (hip_track_q),
		.foot_track_width (foot_track_q),
		.stand_height     (stand_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.leg_index        (leg_index),
		.foot_x           (foot_x),
		.foot_y           (foot_y),
		.foot_z           (foot_z),
		.last_leg         (last_leg)
	);

	// An item is never taken while the queue has no room for it.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !q_stat.full)
		else $error("input item accepted with a full queue");

	// The back end only pops an item that is present.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	// The last-leg flag marks exactly the fourth leg.
	a_last_leg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_leg == (leg_index == 2'd3)))
		else $error("last_leg does not match leg_index");

endmodule

// ----- verif/tb_pose_ramp_foot_positions_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pose_ramp_foot_positions_core
// Self-checking bench for the pose ramp and foot position solver. A queue-fed
// driver sends pose targets with random gaps. A monitor stalls the result side
// at random and compares each leg result against a bit-exact predictor of the
// ramp, the series trigonometry and the leg equations. Register settings
// change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_pose_ramp_foot_positions_core;

	localparam int CLEAR_CYCLES  = 150;
	localparam int WATCHDOG_MAX  = 6000;
	localparam logic [prfp_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [prfp_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		logic signed [prfp_pkg::TGT_W-1:0] pitch;
		logic signed [prfp_pkg::TGT_W-1:0] roll;
		logic signed [prfp_pkg::TGT_W-1:0] shift;
		logic [prfp_pkg::STEP_W-1:0]       step;
	} pose_cmd_t;

	typedef struct {
		logic [1:0]  leg;
		logic [23:0] x;
		logic [23:0] y;
		logic [23:0] z;
		logic        last;
	} leg_pos_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [prfp_pkg::TGT_W-1:0] target_pitch = '0;
	logic signed [prfp_pkg::TGT_W-1:0] target_roll = '0;
	logic signed [prfp_pkg::TGT_W-1:0] target_shift = '0;
	logic [prfp_pkg::STEP_W-1:0] step_size = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] leg_index;
	logic signed [23:0] foot_x, foot_y, foot_z;
	logic last_leg;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [prfp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [prfp_pkg::CFG_W-1:0] cfg_data = '0;

	pose_cmd_t pending_cmds[$];
	leg_pos_t  expected_legs[$];
	logic hold_sender = 1'b0;
	int errors = 0;
	int cmds_sent = 0;
	int legs_checked = 0;
	int reg_writes = 0;
	int quiet_cycles = 0;

	// Predictor state.
	longint base_len, hip_track, foot_track, stand_h;
	longint pitch_cur, roll_cur, shift_cur;

	pose_ramp_foot_positions_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.target_pitch(target_pitch), .target_roll(target_roll),
		.target_shift(target_shift), .step_size(step_size),
		.out_valid(out_valid), .out_stall(out_stall),
		.leg_index(leg_index), .foot_x(foot_x), .foot_y(foot_y), .foot_z(foot_z),
		.last_leg(last_leg),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic longint clip(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		clip = v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint round_shift(input longint v, input int sh);
		longint unsigned mag;
		mag = v < 0 ? longint'(0) - v : v;
		mag = (mag + (longint'(1) << (sh - 1))) >> sh;
		round_shift = v < 0 ? -longint'(mag) : longint'(mag);
	endfunction

	// First-quadrant sine and cosine in Q2.30 from truncated Taylor series.
	function automatic void quadrant_trig(input longint unsigned r,
			output longint s, output longint c);
		longint unsigned sin_div[5] = '{110, 72, 42, 20, 6};
		longint unsigned cos_div[5] = '{132, 90, 56, 30, 12};
		longint unsigned one, x, x2, t;
		longint cv;
		one = longint'(1) << 30;
		x = r * prfp_pkg::RAD_PER_UNIT;
		x2 = (x * x) >> 30;
		t = one;
		for (int i = 0; i < 5; i++)
			t = one - ((x2 * t) >> 30) / sin_div[i];
		s = longint'((x * t) >> 30);
		t = one;
		for (int i = 0; i < 5; i++)
			t = one - ((x2 * t) >> 30) / cos_div[i];
		cv = longint'(one) - longint'((x2 * t) >> 31);
		c = cv < 0 ? 0 : cv;
	endfunction

	function automatic void angle_trig(input longint a, output longint s, output longint c);
		longint m, qs, qc;
		m = ((a % prfp_pkg::DEG_FULL) + prfp_pkg::DEG_FULL) % prfp_pkg::DEG_FULL;
		quadrant_trig(m % prfp_pkg::DEG_QUAD, qs, qc);
		case (m / prfp_pkg::DEG_QUAD)
			0: begin s = qs; c = qc; end
			1: begin s = qc; c = -qs; end
			2: begin s = -qs; c = -qc; end
			default: begin s = -qc; c = qs; end
		endcase
	endfunction

	function automatic longint ramp_toward(input longint cur, input longint tgt,
			input longint step);
		if (tgt - cur > prfp_pkg::RAMP_DEAD)
			cur = cur + step;
		else if (cur - tgt > prfp_pkg::RAMP_DEAD)
			cur = cur - step;
		ramp_toward = clip(cur, 16);
	endfunction

	function automatic logic [23:0] to_coord(input longint twice);
		to_coord = 24'(clip(round_shift(twice, 1), 24));
	endfunction

	// Advances the ramp and queues the four leg positions for one pose item.
	task automatic solve_legs(input pose_cmd_t cmd);
		longint sp, cp, sr, cr, lc, bc, bs, lss, lcs, s2, h2;
		longint x[4], y[4], z[4];
		leg_pos_t lp;
		pitch_cur = ramp_toward(pitch_cur, cmd.pitch, cmd.step);
		roll_cur  = ramp_toward(roll_cur, cmd.roll, cmd.step);
		shift_cur = ramp_toward(shift_cur, cmd.shift, cmd.step);
		angle_trig(pitch_cur, sp, cp);
		angle_trig(roll_cur, sr, cr);
		lc  = round_shift(base_len * cp, 30);
		bc  = round_shift(hip_track * cr, 30);
		bs  = round_shift(hip_track * sr, 30);
		lss = round_shift(base_len * round_shift(sp * sr, 30), 30);
		lcs = round_shift(base_len * round_shift(cr * sp, 30), 30);
		s2 = 2 * shift_cur;
		h2 = 2 * stand_h;
		x[0] = base_len - s2 - lc;  y[0] = foot_track - bc - lss;  z[0] = -h2 - bs + lcs;
		x[1] = base_len - s2 - lc;  y[1] = -foot_track + bc - lss; z[1] = -h2 + bs + lcs;
		x[2] = -base_len - s2 + lc; y[2] = -foot_track + bc + lss; z[2] = -h2 + bs - lcs;
		x[3] = -base_len - s2 + lc; y[3] = foot_track - bc + lss;  z[3] = -h2 - bs - lcs;
		for (int k = 0; k < 4; k++) begin
			lp.leg = 2'(k);
			lp.x = to_coord(x[k]);
			lp.y = to_coord(y[k]);
			lp.z = to_coord(z[k]);
			lp.last = (k == 3);
			expected_legs.push_back(lp);
		end
	endtask

	// The long quiet stretch gives both sides back-to-back traffic.
	function automatic logic take_gap();
		take_gap = (cmds_sent < 150 || cmds_sent > 230) && ($urandom_range(99) < 16);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				solve_legs(pending_cmds.pop_front());
				cmds_sent++;
			end
			if (in_valid && in_stall) begin
				// Hold the stalled item as it is.
			end else if (pending_cmds.size() > 0 && !hold_sender && !take_gap()) begin
				in_valid <= 1'b1;
				target_pitch <= pending_cmds[0].pitch;
				target_roll  <= pending_cmds[0].roll;
				target_shift <= pending_cmds[0].shift;
				step_size    <= pending_cmds[0].step;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		leg_pos_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_legs.size() == 0) begin
					$display("%0t: leg result %0d arrived with none expected", $time, leg_index);
					errors++;
				end else begin
					want = expected_legs.pop_front();
					legs_checked++;
					if (leg_index !== want.leg) begin
						$display("%0t: leg_index expected %0d got %0d", $time, want.leg, leg_index);
						errors++;
					end
					if (foot_x !== want.x) begin
						$display("%0t: foot_x expected %0d got %0d", $time,
							$signed(want.x), foot_x);
						errors++;
					end
					if (foot_y !== want.y) begin
						$display("%0t: foot_y expected %0d got %0d", $time,
							$signed(want.y), foot_y);
						errors++;
					end
					if (foot_z !== want.z) begin
						$display("%0t: foot_z expected %0d got %0d", $time,
							$signed(want.z), foot_z);
						errors++;
					end
					if (last_leg !== want.last) begin
						$display("%0t: last_leg expected %0d got %0d", $time, want.last, last_leg);
						errors++;
					end
				end
			end
			out_stall <= take_gap();
		end
	end

	// Ends the run when no channel has moved an item for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG_MAX) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [prfp_pkg::CFG_IDX_W-1:0] idx,
			input logic [prfp_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			prfp_pkg::REG_HIP_BASE:   base_len = val;
			prfp_pkg::REG_HIP_TRACK:  hip_track = val;
			prfp_pkg::REG_FOOT_TRACK: foot_track = val;
			prfp_pkg::REG_STAND:      stand_h = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() > 0 || in_valid || expected_legs.size() > 0)
			@(posedge clk);
		repeat (CLEAR_CYCLES) @(posedge clk);
	endtask

	task automatic add_cmd(input int p, input int r, input int s, input int st);
		pose_cmd_t c;
		c.pitch = p[prfp_pkg::TGT_W-1:0];
		c.roll = r[prfp_pkg::TGT_W-1:0];
		c.shift = s[prfp_pkg::TGT_W-1:0];
		c.step = st[prfp_pkg::STEP_W-1:0];
		pending_cmds.push_back(c);
	endtask

	// Mostly targets near a moving set point so the ramp settles and crosses
	// the dead band; the rest are arbitrary full-range targets.
	task automatic add_random(input int count);
		int cp, cr, cs;
		cp = 0; cr = 0; cs = 0;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) < 7) begin
				if ($urandom_range(7) == 0) begin
					cp = $urandom_range(65535) - 32768;
					cr = $urandom_range(65535) - 32768;
					cs = $urandom_range(65535) - 32768;
				end
				add_cmd(cp + $urandom_range(1200) - 600, cr + $urandom_range(1200) - 600,
					cs + $urandom_range(1200) - 600, $urandom_range(640));
			end else begin
				add_cmd($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
					$urandom_range(65535) - 32768, $urandom_range(2560));
			end
		end
	endtask

	initial begin
		base_len = prfp_pkg::HIP_BASE_RST;
		hip_track = prfp_pkg::HIP_TRACK_RST;
		foot_track = prfp_pkg::FOOT_TRACK_RST;
		stand_h = prfp_pkg::STAND_RST;
		pitch_cur = 0;
		roll_cur = 0;
		shift_cur = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: dead band edges, overshoot, saturation, wrapping angles.
		add_cmd(0, 0, 0, 0);
		add_cmd(256, -256, 256, 2560);
		add_cmd(257, -257, 257, 100);
		add_cmd(300, -300, 300, 2560);
		add_cmd(32767, 32767, 32767, 2560);
		repeat (12) add_cmd(32767, -32768, 32767, 2560);
		add_cmd(-32768, 32767, -32768, 2560);
		add_cmd(-32768, -32768, -32768, 4095 & 2560);
		add_cmd(23040, -23040, 0, 1);
		add_cmd(-1, 1, -1, 2048);
		wait_idle();

		write_reg(prfp_pkg::REG_HIP_BASE, 20'hFFFFF);
		write_reg(prfp_pkg::REG_HIP_TRACK, 20'hFFFFF);
		write_reg(prfp_pkg::REG_FOOT_TRACK, 20'hFFFFF);
		write_reg(prfp_pkg::REG_STAND, 20'hFFFFF);
		add_cmd(-32768, 32767, -32768, 2560);
		add_cmd(11520, 11520, 32767, 2560);
		add_random(86);
		while (pending_cmds.size() > 45) @(posedge clk);
		hold_sender = 1'b1;
		while (in_valid || expected_legs.size() > 0) @(posedge clk);
		hold_sender = 1'b0;
		wait_idle();

		write_reg(prfp_pkg::REG_HIP_BASE, '0);
		write_reg(prfp_pkg::REG_HIP_TRACK, '0);
		write_reg(prfp_pkg::REG_FOOT_TRACK, '0);
		write_reg(prfp_pkg::REG_STAND, '0);
		write_reg(REG_SPARE_LO, 20'h12345);
		add_random(88);
		wait_idle();

		for (int ph = 0; ph < 2; ph++) begin
			write_reg(prfp_pkg::REG_HIP_BASE, 20'($urandom_range(1048575)));
			write_reg(prfp_pkg::REG_HIP_TRACK, 20'($urandom_range(1048575)));
			write_reg(prfp_pkg::REG_FOOT_TRACK, 20'($urandom_range(1048575)));
			write_reg(prfp_pkg::REG_STAND, 20'($urandom_range(1048575)));
			write_reg(REG_SPARE_HI, 20'($urandom_range(1048575)));
			add_random(88);
			wait_idle();
		end

		$display("Sent %0d pose items and checked %0d leg results over %0d register writes,",
			cmds_sent, legs_checked, reg_writes);
		$display("covering reset, all-ones, all-zero and random geometry settings.");
		if (errors == 0 && expected_legs.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d leg results missing", errors, expected_legs.size());
			$display("simulation failed");
		end
		$finish;
	end

endmodule
